FILE: rtl/tgasd_pkg.sv
// Shared types, codes and a helper function for the TGA stream decoder.
package tgasd_pkg;

    localparam int HEADER_LEN = 18;

    localparam logic [7:0] TYPE_NONE      = 8'd0;
    localparam logic [7:0] TYPE_CMAP      = 8'd1;
    localparam logic [7:0] TYPE_TRUE      = 8'd2;
    localparam logic [7:0] TYPE_GRAY      = 8'd3;
    localparam logic [7:0] TYPE_CMAP_RLE  = 8'd9;
    localparam logic [7:0] TYPE_TRUE_RLE  = 8'd10;
    localparam logic [7:0] TYPE_GRAY_RLE  = 8'd11;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [6:0] PKT_LEN_MASK = 7'h7f;
    localparam logic [15:0] RGB16_R_MASK = 16'h7C00;
    localparam logic [15:0] RGB16_G_MASK = 16'h03E0;
    localparam logic [15:0] RGB16_B_MASK = 16'h001F;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ID     = 3'd1,
        PH_CMAP   = 3'd2,
        PH_PIXELS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        FMT_CMAP   = 3'd0,
        FMT_RGB16  = 3'd1,
        FMT_RGB24  = 3'd2,
        FMT_RGBA32 = 3'd3,
        FMT_GRAY8  = 3'd4,
        FMT_GRAY16 = 3'd5
    } fmt_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       file_start;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       last_pixel;
        logic       status;
    } out_t;

    // One decoded pixel (or error) handed from the parser to the colour stage.
    typedef struct packed {
        logic        valid;
        logic        status;
        fmt_t        fmt;
        logic [31:0] bytes;
        logic [7:0]  count;
        logic        last;
    } pix_item_t;

    function automatic logic [2:0] fmt_bytes(input fmt_t f);
        logic [2:0] n;
        case (f)
            FMT_CMAP:   n = 3'd1;
            FMT_RGB16:  n = 3'd2;
            FMT_RGB24:  n = 3'd3;
            FMT_RGBA32: n = 3'd4;
            FMT_GRAY8:  n = 3'd1;
            FMT_GRAY16: n = 3'd2;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/tgasd_ram.sv
// Generic single-port-write, registered-read RAM.
module tgasd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/tgasd_parse.sv
// Byte parser: header, ID skip, colormap store and pixel assembly.
module tgasd_parse #(
    parameter int PALETTE_BYTES = 768,
    parameter int COUNT_BITS    = 32,
    parameter int ROW_BITS      = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  tgasd_pkg::in_t         in_word,
    output tgasd_pkg::pix_item_t   item,
    output logic [2:0]             pal_we,
    output logic [ROW_BITS-1:0]    pal_waddr,
    output logic [7:0]             pal_wdata
);
    localparam int LAST_ROW  = (PALETTE_BYTES - 1) / 3;
    localparam int LAST_LANE = (PALETTE_BYTES - 1) % 3;
    localparam logic [32:0] CMAX = (33'd1 << COUNT_BITS) - 33'd1;

    tgasd_pkg::phase_t phase_reg, phase_next, c_phase;
    logic [4:0]  hidx_reg, hidx_next, c_hidx;
    logic [7:0]  hdr_reg [tgasd_pkg::HEADER_LEN];
    logic [7:0]  skip_reg, skip_next, c_skip, skip_dec;
    logic [20:0] cmap_reg, cmap_next, c_cmap, cm_dec, cm_hdr, cmap_len_reg;
    logic [1:0]  lane_reg, lane_next, c_lane;
    logic [ROW_BITS-1:0] row_reg, row_next, c_row;
    logic        full_reg, full_next, c_full;
    logic [COUNT_BITS-1:0] total_reg, done_reg, done_next, c_done, done_new;
    logic [7:0]  pkt_reg, pkt_next, c_pkt, pkt_new, count;
    logic        run_reg, run_next, c_run;
    logic [1:0]  bip_reg, bip_next, c_bip, bip_inc;
    logic [31:0] pb_reg, pb_next, c_pb, pb_new;
    tgasd_pkg::fmt_t fmt_reg, fmt_next, beg_fmt;
    logic        rle_reg, rle_next;
    logic [31:0] prod;
    logic [COUNT_BITS:0] sum;
    logic [7:0]  byte_in, after_skip;
    logic [20:0] after_cm;
    logic        fs, hdr_end, in_after, go_begin, beg_err, beg_ok, beg_go;
    logic        is_pkt_hdr, complete, last, pix_emit, err_emit;

    assign byte_in = in_word.file_byte;
    assign fs      = in_word.file_start;

    // Restart view of the state when this word opens a new file.
    assign c_phase = fs ? tgasd_pkg::PH_HEADER : phase_reg;
    assign c_hidx  = fs ? 5'd0 : hidx_reg;
    assign c_skip  = fs ? 8'd0 : skip_reg;
    assign c_cmap  = fs ? 21'd0 : cmap_reg;
    assign c_lane  = fs ? 2'd0 : lane_reg;
    assign c_row   = fs ? '0 : row_reg;
    assign c_full  = fs ? 1'b0 : full_reg;
    assign c_done  = fs ? '0 : done_reg;
    assign c_pkt   = fs ? 8'd0 : pkt_reg;
    assign c_run   = fs ? 1'b0 : run_reg;
    assign c_bip   = fs ? 2'd0 : bip_reg;
    assign c_pb    = fs ? 32'd0 : pb_reg;

    // Header products, registered ahead of the last header byte.
    assign prod = {hdr_reg[13], hdr_reg[12]} * {hdr_reg[15], hdr_reg[14]};
    always_ff @(posedge aclk) begin
        cmap_len_reg <= 21'({hdr_reg[6], hdr_reg[5]} * 21'(hdr_reg[7][7:3]));
        if ({1'b0, prod} > CMAX) begin
            total_reg <= '1;
        end else begin
            total_reg <= prod[COUNT_BITS-1:0];
        end
    end

    // Image type decode.
    always_comb begin
        beg_err = 1'b0;
        beg_ok  = 1'b1;
        beg_fmt = tgasd_pkg::FMT_CMAP;
        case (hdr_reg[2])
            tgasd_pkg::TYPE_NONE: beg_ok = 1'b0;
            tgasd_pkg::TYPE_CMAP, tgasd_pkg::TYPE_CMAP_RLE: beg_fmt = tgasd_pkg::FMT_CMAP;
            tgasd_pkg::TYPE_TRUE, tgasd_pkg::TYPE_TRUE_RLE: begin
                if (hdr_reg[16] == 8'd16) begin
                    beg_fmt = tgasd_pkg::FMT_RGB16;
                end else if (hdr_reg[16] == 8'd24) begin
                    beg_fmt = tgasd_pkg::FMT_RGB24;
                end else if (hdr_reg[16] == 8'd32) begin
                    beg_fmt = tgasd_pkg::FMT_RGBA32;
                end else begin
                    beg_ok = 1'b0;
                end
            end
            tgasd_pkg::TYPE_GRAY, tgasd_pkg::TYPE_GRAY_RLE:
                beg_fmt = (hdr_reg[16] == 8'd8) ? tgasd_pkg::FMT_GRAY8
                                                 : tgasd_pkg::FMT_GRAY16;
            default: begin
                beg_err = 1'b1;
                beg_ok  = 1'b0;
            end
        endcase
    end
    assign beg_go = beg_ok && (total_reg != '0);

    // Phase transitions.
    assign hdr_end    = (c_phase == tgasd_pkg::PH_HEADER) && (c_hidx == 5'd17);
    assign cm_hdr     = (hdr_reg[1] != 8'd0) ? cmap_len_reg : 21'd0;
    assign skip_dec   = (c_skip != 8'd0) ? c_skip - 8'd1 : 8'd0;
    assign cm_dec     = (c_cmap != 21'd0) ? c_cmap - 21'd1 : 21'd0;
    assign after_skip = hdr_end ? hdr_reg[0] : skip_dec;
    assign after_cm   = hdr_end ? cm_hdr : c_cmap;
    assign in_after   = hdr_end || (c_phase == tgasd_pkg::PH_ID);
    assign go_begin   = (in_after && after_skip == 8'd0 && after_cm == 21'd0)
                     || (c_phase == tgasd_pkg::PH_CMAP && cm_dec == 21'd0);

    // Pixel assembly.
    assign is_pkt_hdr = rle_reg && (c_pkt == 8'd0);
    assign bip_inc    = c_bip + 2'd1;
    assign complete   = (bip_inc == 2'd0) || ({1'b0, bip_inc} >= tgasd_pkg::fmt_bytes(fmt_reg));
    always_comb begin
        pb_new = c_pb;
        case (c_bip)
            2'd0:    pb_new[7:0]   = c_pb[7:0]   | byte_in;
            2'd1:    pb_new[15:8]  = c_pb[15:8]  | byte_in;
            2'd2:    pb_new[23:16] = c_pb[23:16] | byte_in;
            default: pb_new[31:24] = c_pb[31:24] | byte_in;
        endcase
    end
    assign count   = (rle_reg && c_run) ? c_pkt : 8'd1;
    assign pkt_new = !rle_reg ? c_pkt : (c_run ? 8'd0 : c_pkt - 8'd1);
    assign sum     = {1'b0, c_done} + (COUNT_BITS + 1)'(count);
    assign done_new = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    assign last    = done_new >= total_reg;
    assign pix_emit = (c_phase == tgasd_pkg::PH_PIXELS) && !is_pkt_hdr && complete;
    assign err_emit = go_begin && beg_err;

    always_comb begin
        phase_next = c_phase;
        if (go_begin) begin
            phase_next = beg_go ? tgasd_pkg::PH_PIXELS : tgasd_pkg::PH_DONE;
        end else begin
            case (c_phase)
                tgasd_pkg::PH_HEADER, tgasd_pkg::PH_ID: begin
                    if (in_after) begin
                        phase_next = (after_skip != 8'd0) ? tgasd_pkg::PH_ID
                                                          : tgasd_pkg::PH_CMAP;
                    end
                end
                tgasd_pkg::PH_PIXELS: begin
                    if (pix_emit && last && (!rle_reg || pkt_new == 8'd0)) begin
                        phase_next = tgasd_pkg::PH_DONE;
                    end
                end
                default: phase_next = c_phase;
            endcase
        end
    end

    always_comb begin
        hidx_next = c_hidx;
        skip_next = c_skip;
        cmap_next = c_cmap;
        lane_next = c_lane;
        row_next  = c_row;
        full_next = c_full;
        done_next = c_done;
        pkt_next  = c_pkt;
        run_next  = c_run;
        bip_next  = c_bip;
        pb_next   = c_pb;
        fmt_next  = fmt_reg;
        rle_next  = rle_reg;
        case (c_phase)
            tgasd_pkg::PH_HEADER: begin
                hidx_next = hdr_end ? 5'd0 : c_hidx + 5'd1;
                if (hdr_end) begin
                    skip_next = hdr_reg[0];
                    cmap_next = cm_hdr;
                    lane_next = 2'd0;
                    row_next  = '0;
                    full_next = 1'b0;
                end
            end
            tgasd_pkg::PH_ID:   skip_next = skip_dec;
            tgasd_pkg::PH_CMAP: begin
                cmap_next = cm_dec;
                if (!c_full) begin
                    if (32'(c_row) == 32'(LAST_ROW) && 32'(c_lane) == 32'(LAST_LANE)) begin
                        full_next = 1'b1;
                    end else if (c_lane == 2'd2) begin
                        lane_next = 2'd0;
                        row_next  = c_row + 1'b1;
                    end else begin
                        lane_next = c_lane + 2'd1;
                    end
                end
            end
            tgasd_pkg::PH_PIXELS: begin
                if (is_pkt_hdr) begin
                    run_next = byte_in[7];
                    pkt_next = {1'b0, byte_in[6:0] & tgasd_pkg::PKT_LEN_MASK} + 8'd1;
                end else if (complete) begin
                    bip_next  = 2'd0;
                    pb_next   = 32'd0;
                    pkt_next  = pkt_new;
                    done_next = done_new;
                end else begin
                    bip_next = bip_inc;
                    pb_next  = pb_new;
                end
            end
            default: hidx_next = c_hidx;
        endcase
        if (go_begin && beg_go) begin
            fmt_next  = beg_fmt;
            rle_next  = hdr_reg[2][3];
            done_next = '0;
            pkt_next  = 8'd0;
            run_next  = 1'b0;
            bip_next  = 2'd0;
            pb_next   = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= tgasd_pkg::PH_HEADER;
            hidx_reg  <= 5'd0;
            skip_reg  <= 8'd0;
            cmap_reg  <= 21'd0;
            lane_reg  <= 2'd0;
            row_reg   <= '0;
            full_reg  <= 1'b0;
            done_reg  <= '0;
            pkt_reg   <= 8'd0;
            run_reg   <= 1'b0;
            bip_reg   <= 2'd0;
            pb_reg    <= 32'd0;
            fmt_reg   <= tgasd_pkg::FMT_CMAP;
            rle_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            hidx_reg  <= hidx_next;
            skip_reg  <= skip_next;
            cmap_reg  <= cmap_next;
            lane_reg  <= lane_next;
            row_reg   <= row_next;
            full_reg  <= full_next;
            done_reg  <= done_next;
            pkt_reg   <= pkt_next;
            run_reg   <= run_next;
            bip_reg   <= bip_next;
            pb_reg    <= pb_next;
            fmt_reg   <= fmt_next;
            rle_reg   <= rle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && c_phase == tgasd_pkg::PH_HEADER) begin
            hdr_reg[c_hidx] <= byte_in;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pal_we[k] = accept && (c_phase == tgasd_pkg::PH_CMAP) && !c_full
                     && (c_lane == 2'(k));
        end
    end
    assign pal_waddr = c_row;
    assign pal_wdata = byte_in;

    always_comb begin
        item.valid  = accept && (pix_emit || err_emit);
        item.status = err_emit;
        item.fmt    = fmt_reg;
        item.bytes  = pb_new;
        item.count  = err_emit ? 8'd0 : count;
        item.last   = !err_emit && last;
    end
endmodule

FILE: rtl/tgasd_pixel.sv
// Colour stage and output register: palette lookup and RGBA expansion.
module tgasd_pixel #(
    parameter int PALETTE_BYTES = 768
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tgasd_pkg::pix_item_t item,
    input  logic [23:0]          pal_rdata,
    output logic                 advance,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tgasd_pkg::out_t      m_data
);
    tgasd_pkg::pix_item_t s1_reg;
    tgasd_pkg::out_t      col, m_data_reg;
    logic                 m_valid_reg, out_free;
    logic [7:0]           b0, b1, b2, b3;
    logic [15:0]          w;
    logic [2:0]           pal_ok;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = !s1_reg.valid || out_free;

    assign b0 = s1_reg.bytes[7:0];
    assign b1 = s1_reg.bytes[15:8];
    assign b2 = s1_reg.bytes[23:16];
    assign b3 = s1_reg.bytes[31:24];
    assign w  = {b1, b0};

    // Palette bytes past storage read as zero.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pal_ok[k] = (({2'b0, b0} * 10'd3) + 10'(k)) < 10'(PALETTE_BYTES);
        end
    end

    always_comb begin
        col.alpha        = tgasd_pkg::ALPHA_OPAQUE;
        col.red          = b0;
        col.green        = b0;
        col.blue         = b0;
        col.repeat_count = s1_reg.count;
        col.last_pixel   = s1_reg.last;
        col.status       = s1_reg.status;
        case (s1_reg.fmt)
            tgasd_pkg::FMT_CMAP: begin
                col.red   = pal_ok[2] ? pal_rdata[23:16] : 8'd0;
                col.green = pal_ok[1] ? pal_rdata[15:8]  : 8'd0;
                col.blue  = pal_ok[0] ? pal_rdata[7:0]   : 8'd0;
            end
            tgasd_pkg::FMT_RGB16: begin
                col.red   = {5'((w & tgasd_pkg::RGB16_R_MASK) >> 10), 3'd0};
                col.green = {5'((w & tgasd_pkg::RGB16_G_MASK) >> 5), 3'd0};
                col.blue  = {5'(w & tgasd_pkg::RGB16_B_MASK), 3'd0};
            end
            tgasd_pkg::FMT_RGB24: begin
                col.red  = b2;
                col.green = b1;
                col.blue = b0;
            end
            tgasd_pkg::FMT_RGBA32: begin
                col.red   = b2;
                col.green = b1;
                col.blue  = b0;
                col.alpha = b3;
            end
            tgasd_pkg::FMT_GRAY8: col.alpha = tgasd_pkg::ALPHA_OPAQUE;
            default:              col.alpha = b1;
        endcase
        if (s1_reg.status) begin
            col.red   = 8'd0;
            col.green = 8'd0;
            col.blue  = 8'd0;
            col.alpha = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (advance) begin
                s1_reg.valid <= item.valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_reg.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_reg.status <= item.status;
            s1_reg.fmt    <= item.fmt;
            s1_reg.bytes  <= item.bytes;
            s1_reg.count  <= item.count;
            s1_reg.last   <= item.last;
        end
        if (out_free) begin
            m_data_reg <= col;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

FILE: rtl/tga_stream_decoder_unit.sv
// Top level of the TGA stream decoder: parser, palette memory, colour stage.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------------------
//  s_      | in        | s_valid / s_ready   | in_t: file_byte, file_start
//  m_      | out       | m_valid / m_ready   | out_t: RGBA, repeat_count, last, status
//
// One file byte is taken every cycle while the result side keeps up; each
// byte does a fixed amount of work in the parser. A pixel is registered in
// the colour stage together with its palette read, then in the output
// register. Reset clears the parse state at once; the palette needs no
// clearing. When the output register is full and not taken, the colour stage
// holds and s_ready drops only if that stage is also occupied.
module tga_stream_decoder_unit #(
    parameter int PALETTE_BYTES = 768,
    parameter int COUNT_BITS    = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  tgasd_pkg::in_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output tgasd_pkg::out_t m_data
);
    // Palette split into three byte lanes so one index reads R, G and B at once.
    localparam int ROWS     = (PALETTE_BYTES + 2) / 3;
    localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RAM_DEPTH = 1 << ROW_BITS;

    tgasd_pkg::pix_item_t item;
    logic                 accept, advance;
    logic [2:0]           pal_we;
    logic [ROW_BITS-1:0]  pal_waddr, pal_raddr;
    logic [7:0]           pal_wdata;
    logic [23:0]          pal_rdata;

    // Take a word only when the colour stage can move.
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    tgasd_parse #(
        .PALETTE_BYTES(PALETTE_BYTES),
        .COUNT_BITS   (COUNT_BITS),
        .ROW_BITS     (ROW_BITS)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_word  (s_data),
        .item     (item),
        .pal_we   (pal_we),
        .pal_waddr(pal_waddr),
        .pal_wdata(pal_wdata)
    );

    // Palette index is the first pixel byte; out-of-range rows are masked later.
    assign pal_raddr = item.bytes[ROW_BITS-1:0];

    for (genvar k = 0; k < 3; k++) begin : g_lane
        tgasd_ram #(
            .WIDTH(8),
            .DEPTH(RAM_DEPTH)
        ) u_ram (
            .aclk (aclk),
            .we   (pal_we[k]),
            .waddr(pal_waddr),
            .wdata(pal_wdata),
            .re   (advance),
            .raddr(pal_raddr),
            .rdata(pal_rdata[8*k +: 8])
        );
    end

    tgasd_pixel #(
        .PALETTE_BYTES(PALETTE_BYTES)
    ) u_pixel (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .item     (item),
        .pal_rdata(pal_rdata),
        .advance  (advance),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );
endmodule

FILE: test/tga_stream_decoder_checker.sv
// Watches both channels, predicts every decoded pixel and compares it with the block.
module tga_stream_decoder_checker
    import tgasd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  in_t  s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  out_t m_data,
    output int   fail_count,
    output int   pixels_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAL_DEPTH = 768;
    localparam longint unsigned PIX_SAT = 64'hFFFF_FFFF;

    logic [7:0]      hdr [HEADER_LEN];
    logic [7:0]      pal [PAL_DEPTH];
    phase_t          phase;
    fmt_t            fmt;
    bit              rle;
    int unsigned     hdr_pos, id_left, pal_pos, cmap_left;
    longint unsigned pix_seen, pix_total;
    int unsigned     pkt_left, byte_pos;
    bit              pkt_run;
    logic [31:0]     pix_acc;
    out_t            pixel_fifo [$];

    function automatic int unsigned hdr_word(int unsigned pos);
        return {hdr[pos+1], hdr[pos]};
    endfunction

    function automatic int unsigned width_of(fmt_t f);
        case (f)
            FMT_RGB16, FMT_GRAY16: return 2;
            FMT_RGB24:             return 3;
            FMT_RGBA32:            return 4;
            default:               return 1;
        endcase
    endfunction

    function automatic logic [7:0] pal_byte(int unsigned pos);
        return (pos < PAL_DEPTH) ? pal[pos] : 8'd0;
    endfunction

    task automatic restart_parse();
        phase     = PH_HEADER;
        hdr_pos   = 0;
        id_left   = 0;
        cmap_left = 0;
        pal_pos   = 0;
        pix_seen  = 0;
        pkt_left  = 0;
        pkt_run   = 0;
        byte_pos  = 0;
        pix_acc   = '0;
    endtask

    task automatic open_image(output bit has, output out_t res);
        logic [7:0]      itype;
        logic [7:0]      depth;
        longint unsigned area;
        itype = hdr[2];
        depth = hdr[16];
        area  = longint'(hdr_word(12)) * longint'(hdr_word(14));
        has   = 0;
        res   = '0;
        phase = PH_DONE;
        case (itype)
            TYPE_NONE: return;
            TYPE_CMAP, TYPE_CMAP_RLE: fmt = FMT_CMAP;
            TYPE_TRUE, TYPE_TRUE_RLE: begin
                if (depth == 8'd16) fmt = FMT_RGB16;
                else if (depth == 8'd24) fmt = FMT_RGB24;
                else if (depth == 8'd32) fmt = FMT_RGBA32;
                else return;
            end
            TYPE_GRAY, TYPE_GRAY_RLE: fmt = (depth == 8'd8) ? FMT_GRAY8 : FMT_GRAY16;
            default: begin
                has        = 1;
                res.status = 1'b1;
                return;
            end
        endcase
        rle       = (itype >= TYPE_CMAP_RLE);
        pix_total = (area > PIX_SAT) ? PIX_SAT : area;
        if (pix_total == 0) return;
        phase    = PH_PIXELS;
        pix_seen = 0;
        pkt_left = 0;
        pkt_run  = 0;
        byte_pos = 0;
        pix_acc  = '0;
    endtask

    task automatic next_part(output bit has, output out_t res);
        has = 0;
        res = '0;
        if (id_left != 0) phase = PH_ID;
        else if (cmap_left != 0) phase = PH_CMAP;
        else open_image(has, res);
    endtask

    task automatic pixel_word(logic [7:0] b, output bit has, output out_t res);
        logic [7:0]      b0, b1, b2, b3;
        logic [15:0]     w16;
        int unsigned     cnt;
        longint unsigned sum;
        has = 0;
        res = '0;
        if (rle && pkt_left == 0) begin
            pkt_run  = b[7];
            pkt_left = (b & PKT_LEN_MASK) + 1;
            return;
        end
        pix_acc  = pix_acc | (32'(b) << (8 * byte_pos));
        byte_pos = (byte_pos + 1) & 3;
        if (byte_pos != 0 && byte_pos < width_of(fmt)) return;
        {b3, b2, b1, b0} = pix_acc;
        res.alpha = ALPHA_OPAQUE;
        case (fmt)
            FMT_CMAP: begin
                res.red   = pal_byte(b0 * 3 + 2);
                res.green = pal_byte(b0 * 3 + 1);
                res.blue  = pal_byte(b0 * 3);
            end
            FMT_RGB16: begin
                w16       = {b1, b0};
                res.red   = 8'(((w16 & RGB16_R_MASK) >> 10) << 3);
                res.green = 8'(((w16 & RGB16_G_MASK) >> 5) << 3);
                res.blue  = 8'((w16 & RGB16_B_MASK) << 3);
            end
            FMT_RGB24: begin
                res.red = b2; res.green = b1; res.blue = b0;
            end
            FMT_RGBA32: begin
                res.red = b2; res.green = b1; res.blue = b0; res.alpha = b3;
            end
            FMT_GRAY8: begin
                res.red = b0; res.green = b0; res.blue = b0;
            end
            default: begin
                res.red = b0; res.green = b0; res.blue = b0; res.alpha = b1;
            end
        endcase
        byte_pos = 0;
        pix_acc  = '0;
        cnt = 1;
        if (rle) begin
            if (pkt_run) begin
                cnt      = pkt_left;
                pkt_left = 0;
            end else begin
                pkt_left = pkt_left - 1;
            end
        end
        sum      = pix_seen + cnt;
        pix_seen = (sum > PIX_SAT) ? PIX_SAT : sum;
        res.repeat_count = 8'(cnt);
        res.last_pixel   = (pix_seen >= pix_total);
        if (res.last_pixel && (!rle || pkt_left == 0)) phase = PH_DONE;
        has = 1;
    endtask

    task automatic decode_word(in_t w, output bit has, output out_t res);
        has = 0;
        res = '0;
        if (w.file_start) restart_parse();
        case (phase)
            PH_HEADER: begin
                if (hdr_pos < HEADER_LEN) hdr[hdr_pos] = w.file_byte;
                hdr_pos++;
                if (hdr_pos < HEADER_LEN) return;
                hdr_pos   = 0;
                id_left   = hdr[0];
                cmap_left = (hdr[1] != 0) ? hdr_word(5) * (hdr[7] >> 3) : 0;
                pal_pos   = 0;
                next_part(has, res);
            end
            PH_ID: begin
                if (id_left != 0) id_left--;
                next_part(has, res);
            end
            PH_CMAP: begin
                if (pal_pos < PAL_DEPTH) pal[pal_pos] = w.file_byte;
                pal_pos++;
                if (cmap_left != 0) cmap_left--;
                if (cmap_left == 0) open_image(has, res);
            end
            PH_PIXELS: pixel_word(w.file_byte, has, res);
            default: ;
        endcase
    endtask

    task automatic compare_pixel(out_t got);
        out_t want;
        if (pixel_fifo.size() == 0) begin
            $error("result word with nothing expected: %h", got);
            fail_count++;
            return;
        end
        want = pixel_fifo.pop_front();
        if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red); fail_count++;
        end
        if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green); fail_count++;
        end
        if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue); fail_count++;
        end
        if (got.alpha !== want.alpha) begin
            $error("alpha: expected %0d, got %0d", want.alpha, got.alpha); fail_count++;
        end
        if (got.repeat_count !== want.repeat_count) begin
            $error("repeat_count: expected %0d, got %0d", want.repeat_count,
                   got.repeat_count);
            fail_count++;
        end
        if (got.last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
            fail_count++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status); fail_count++;
        end
    endtask

    initial begin
        fail_count  = 0;
        pixels_owed = 0;
        for (int i = 0; i < HEADER_LEN; i++) hdr[i] = '0;
        fmt = FMT_CMAP;
        rle = 0;
        pix_total = 0;
        restart_parse();
    end

    always @(posedge aclk) begin
        bit   has;
        out_t res;
        if (!aresetn) begin
            for (int i = 0; i < HEADER_LEN; i++) hdr[i] = '0;
            fmt = FMT_CMAP;
            rle = 0;
            pix_total = 0;
            restart_parse();
            pixel_fifo.delete();
        end else begin
            if (m_valid && m_ready) compare_pixel(m_data);
            if (s_valid && s_ready) begin
                decode_word(s_data, has, res);
                if (has) pixel_fifo.push_back(res);
            end
        end
        pixels_owed = pixel_fifo.size();
    end

endmodule

FILE: test/tga_stream_decoder_unit_tb.sv
// Top of the decoder testbench: builds TGA files, drives them in and gives the verdict.
module tga_stream_decoder_unit_tb;
    import tgasd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;
    int   fail_count;
    int   pixels_owed;

    // Byte stream waiting to go in, and where the current file begins in it.
    in_t file_words [$];
    int  file_base;
    int  burst_left;
    int  words_sent;

    tga_stream_decoder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    tga_stream_decoder_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pixels_owed(pixels_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Queue one byte; the first byte of each file carries the start flag.
    task automatic put(int b);
        in_t w;
        w.file_byte  = 8'(b);
        w.file_start = (file_words.size() == file_base);
        file_words.push_back(w);
    endtask

    task automatic put_header(int idlen, int cm_on, int itype, int cm_len, int cm_size,
                              int w, int h, int depth);
        file_base = file_words.size();
        put(idlen); put(cm_on); put(itype);
        put($urandom); put($urandom);               // first entry index, unused
        put(cm_len); put(cm_len >> 8); put(cm_size);
        repeat (4) put($urandom);                   // origin
        put(w); put(w >> 8); put(h); put(h >> 8);
        put(depth); put($urandom);
        repeat (idlen) put($urandom);
        if (cm_on != 0) repeat (cm_len * (cm_size >> 3)) put($urandom);
    endtask

    // One pixel: a palette index below the written entries, or random bytes.
    task automatic put_pixel(int bpp, int entries);
        if (entries > 0) put($urandom_range(0, entries - 1));
        else repeat (bpp) put($urandom);
    endtask

    // Build a complete file; optionally let RLE packets run past the end,
    // cut it short, or append bytes that must be ignored.
    task automatic build_file(int itype, int depth, int w, int h, int idlen, int cm_len,
                              int cm_size, bit overrun, bit cut, int trailer);
        int bpp, entries, left, n, stored;
        bit run;
        stored = cm_len * (cm_size >> 3);
        if (stored > 768) stored = 768;
        entries = 0;
        if (itype == TYPE_CMAP || itype == TYPE_CMAP_RLE) entries = stored / 3;
        if (entries > 0 || itype == TYPE_GRAY || itype == TYPE_GRAY_RLE)
            bpp = (entries > 0 || depth == 8) ? 1 : 2;
        else
            bpp = depth / 8;
        if (bpp < 1) bpp = 1;
        put_header(idlen, cm_len != 0, itype, cm_len, cm_size, w, h, depth);
        left = w * h;
        if (itype >= TYPE_CMAP_RLE) begin
            while (left > 0) begin
                n = $urandom_range(1, (left < 16) ? left : 16);
                if (overrun && n == left) n = n + $urandom_range(0, 3);
                run = $urandom_range(0, 1);
                put({run, 7'(n - 1)});
                if (run) put_pixel(bpp, entries);
                else repeat (n) put_pixel(bpp, entries);
                left = left - n;
            end
        end else begin
            repeat (left) put_pixel(bpp, entries);
        end
        if (cut) begin
            n = $urandom_range(1, file_words.size() - file_base - 1);
            while (file_words.size() > file_base + n) void'(file_words.pop_back());
        end else begin
            repeat (trailer) put($urandom);
        end
    endtask

    // Offer one word; gaps fall between bursts of random length.
    task automatic send_word(in_t w);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        burst_left--;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Drain everything built so far, then drop valid.
    task automatic send_files();
        while (file_words.size() > 0) send_word(file_words.pop_front());
        s_valid <= 1'b0;
        file_base = 0;
    endtask

    task automatic random_file();
        int sel, itype, depth, w, h, cm_len, cm_size;
        sel = $urandom_range(0, 19);
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        if ($urandom_range(0, 15) == 0) w = 0;
        cm_len = 0;
        cm_size = 24;
        if (sel < 16) begin
            case ($urandom_range(0, 5))
                0: itype = TYPE_CMAP;
                1: itype = TYPE_TRUE;
                2: itype = TYPE_GRAY;
                3: itype = TYPE_CMAP_RLE;
                4: itype = TYPE_TRUE_RLE;
                default: itype = TYPE_GRAY_RLE;
            endcase
        end else if (sel < 19) begin
            itype = $urandom_range(4, 252);
            if (itype >= TYPE_CMAP_RLE && itype <= TYPE_GRAY_RLE) itype += 3;
        end else begin
            itype = TYPE_NONE;
        end
        case (itype)
            TYPE_CMAP, TYPE_CMAP_RLE: begin
                depth = 8;
                cm_len = $urandom_range(2, 8);
                cm_size = 8 * $urandom_range(2, 4);
            end
            TYPE_TRUE, TYPE_TRUE_RLE: begin
                depth = 8 * $urandom_range(2, 4);
                if ($urandom_range(0, 19) == 0) depth = 8;
            end
            TYPE_GRAY, TYPE_GRAY_RLE:
                depth = ($urandom_range(0, 1) == 0) ? 8 : $urandom_range(0, 255);
            default: depth = $urandom_range(0, 255);
        endcase
        if (cm_len == 0 && $urandom_range(0, 3) == 0) cm_len = $urandom_range(1, 3);
        build_file(itype, depth, w, h, $urandom_range(0, 3), cm_len, cm_size,
                   $urandom_range(0, 2) == 0, $urandom_range(0, 9) == 0,
                   $urandom_range(0, 3));
    endtask

    // Receiver: short patterns of stalls, one long hold-off early on.
    initial begin
        int k;
        bit mode;
        m_ready = 1'b0;
        k = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            k++;
            if (k == 30) begin
                m_ready <= 1'b0;
                repeat (500) @(posedge aclk);
            end
            mode = $urandom_range(0, 1);
            repeat ($urandom_range(1, 30)) begin
                m_ready <= mode ? 1'b1 : ($urandom_range(0, 2) != 0);
                @(posedge aclk);
            end
        end
    end

    initial begin
        int idx;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        file_base  = 0;
        burst_left = 0;
        words_sent = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed files: each format, each special case.
        build_file(TYPE_TRUE, 24, 2, 1, 2, 2, 24, 0, 0, 0);
        put_header(0, 0, TYPE_GRAY, 0, 0, 2, 1, 8);
        put(8'h00); put(8'hFF);
        put_header(0, 0, TYPE_TRUE, 0, 0, 3, 1, 16);
        put(8'h00); put(8'h00); put(8'hFF); put(8'hFF); put(8'hFF); put(8'h7F);
        build_file(TYPE_TRUE, 32, 3, 2, 0, 0, 24, 0, 0, 0);
        build_file(TYPE_TRUE_RLE, 32, 3, 2, 1, 0, 24, 1, 0, 2);
        build_file(TYPE_TRUE_RLE, 24, 4, 2, 0, 0, 24, 0, 0, 0);
        build_file(TYPE_TRUE_RLE, 16, 4, 1, 0, 0, 24, 0, 0, 0);
        build_file(TYPE_GRAY_RLE, 8, 5, 1, 0, 0, 24, 1, 0, 0);
        build_file(TYPE_GRAY, 16, 2, 2, 0, 0, 24, 0, 0, 0);
        build_file(TYPE_GRAY, 12, 2, 1, 0, 0, 24, 0, 0, 0);
        // full palette: index 0 and 255 both read written bytes
        put_header(3, 1, TYPE_CMAP, 256, 24, 2, 1, 8);
        put(8'h00); put(8'hFF);
        build_file(TYPE_CMAP_RLE, 8, 4, 2, 0, 4, 32, 1, 0, 0);
        build_file(TYPE_CMAP, 8, 3, 1, 0, 3, 16, 0, 0, 0);
        // palette longer than storage: the tail is dropped
        build_file(TYPE_CMAP, 8, 2, 1, 0, 260, 24, 0, 0, 0);
        // longest run packets, and a width with a nonzero high byte
        put_header(0, 0, TYPE_GRAY_RLE, 0, 0, 300, 1, 8);
        put(8'hFF); put($urandom); put(8'hFF); put($urandom); put(8'hAB); put($urandom);
        build_file(5, 24, 2, 1, 0, 0, 24, 0, 0, 3);
        build_file(255, 24, 2, 1, 2, 2, 24, 0, 0, 0);
        build_file(TYPE_NONE, 24, 2, 1, 0, 0, 24, 0, 0, 2);
        build_file(TYPE_TRUE, 8, 2, 1, 0, 0, 24, 0, 0, 0);
        build_file(TYPE_TRUE, 24, 0, 3, 0, 0, 24, 0, 0, 0);
        build_file(TYPE_TRUE, 24, 3, 1, 0, 0, 24, 0, 1, 0);
        build_file(TYPE_GRAY, 8, 2, 1, 0, 0, 24, 0, 0, 4);
        send_files();

        // Hold until every pixel of the directed files has come out.
        while (pixels_owed != 0) @(posedge aclk);

        idx = words_sent;
        while (words_sent < idx + 550) begin
            random_file();
            send_files();
        end

        while (pixels_owed != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pixels_owed == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
